/* hdl/tcw_pkg.sv */
// Shared types, character codes and register map of the text console writer.
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam logic [7:0] CLEAR_ATTR   = 8'h0F;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;

   localparam logic [1:0] ADDR_TEXT_ATTRIBUTE = 2'd0;

   typedef enum logic [1:0] {
      OP_PUT        = 2'd0,
      OP_SET_CURSOR = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_READ       = 2'd3
   } opcode_type;

   function automatic logic [15:0] blank_cell(input logic [7:0] attr);
      return {attr, SPACE_CHAR};
   endfunction

endpackage

/* hdl/text_console_writer.sv */
// Top level of the text console writer: stream channels, register port, result register.
//
// Text console of COLUMNS x ROWS cells (character low byte, attribute high byte)
// with a linear cursor. Commands enter on the req_ stream, one item per command;
// each command gives exactly one item on the rsp_ stream with the cell read
// (zero for non-read commands), the cursor after the command and a scroll flag.
// The attribute used for written cells is set through the csr_ register port
// (register 0, text_attribute, reset 0x0F); write it only while the block is idle.
//
// Commands run one at a time through the cell store (one write port, one read port).
// A put that scrolls copies every row up, fills the bottom row with blank cells and
// then resumes, also inside a tab; clear screen sweeps the whole store to blank cells.
// After reset the store is swept to blank cells with attribute 0x0F while req_tready is low.
// The result sits in an output register; the next command is accepted while
// it waits, and the engine holds a finished result until that register frees.
module text_console_writer #(
   parameter int  COLUMNS    = tcw_pkg::COLUMNS_DEFAULT,
   parameter int  ROWS       = tcw_pkg::ROWS_DEFAULT,
   localparam int CELL_COUNT = COLUMNS * ROWS,
   localparam int IDX_W      = $clog2(CELL_COUNT),
   localparam int REQ_W      = ((26 + IDX_W + 7) / 8) * 8,
   localparam int RSP_W      = ((17 + IDX_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // command stream
   input  logic             req_tvalid,
   output logic             req_tready,
   // opcode[2], char_code[8], cursor_col[8], cursor_row[8], cell_index[IDX_W], zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // result stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // cell_value[16], cursor_index[IDX_W], scrolled[1], zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   // register port
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [1:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int LAST_ROW_START = CELL_COUNT - COLUMNS;

   logic [7:0]       attr_ff;
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic             eng_valid;
   logic             eng_ready;
   logic [15:0]      eng_cell_value;
   logic [IDX_W-1:0] eng_cursor_index;
   logic             eng_scrolled;

   // register port: always ready, one register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == tcw_pkg::ADDR_TEXT_ATTRIBUTE) ? {24'd0, attr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::CLEAR_ATTR;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == tcw_pkg::ADDR_TEXT_ATTRIBUTE) begin
         attr_ff <= csr_pwdata[7:0];
      end
   end

   tcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .text_attribute   (attr_ff),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_opcode        (tcw_pkg::opcode_type'(req_tdata[1:0])),
      .in_char_code     (req_tdata[9:2]),
      .in_cursor_col    (req_tdata[17:10]),
      .in_cursor_row    (req_tdata[25:18]),
      .in_cell_index    (req_tdata[26 +: IDX_W]),
      .out_valid        (eng_valid),
      .out_ready        (eng_ready),
      .out_cell_value   (eng_cell_value),
      .out_cursor_index (eng_cursor_index),
      .out_scrolled     (eng_scrolled)
   );

   // output register: take a new result when empty or being drained this cycle
   assign eng_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_valid && eng_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_valid && eng_ready) begin
         rsp_data_ff <= RSP_W'({eng_scrolled, eng_cursor_index, eng_cell_value});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // cursor never leaves the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[16 +: IDX_W]) < CELL_COUNT))
      else $error("cursor index beyond last cell");

   // a scroll always leaves the cursor on the bottom row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[16 + IDX_W]) |-> (32'(rsp_tdata[16 +: IDX_W]) >= LAST_ROW_START))
      else $error("scrolled result with cursor above bottom row");

   // no command is taken as the post-reset sweep begins
   a_reset_sweep: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("command accepted during reset sweep");

endmodule

/* hdl/tcw_engine.sv */
// Command sequencer and cell store of the text console writer.
module tcw_engine #(
   parameter int  COLUMNS    = tcw_pkg::COLUMNS_DEFAULT,
   parameter int  ROWS       = tcw_pkg::ROWS_DEFAULT,
   localparam int CELL_COUNT = COLUMNS * ROWS,
   localparam int IDX_W      = $clog2(CELL_COUNT)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           text_attribute,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tcw_pkg::opcode_type  in_opcode,
   input  logic [7:0]           in_char_code,
   input  logic [7:0]           in_cursor_col,
   input  logic [7:0]           in_cursor_row,
   input  logic [IDX_W-1:0]     in_cell_index,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [15:0]          out_cell_value,
   output logic [IDX_W-1:0]     out_cursor_index,
   output logic                 out_scrolled
);

   localparam int COL_W          = $clog2(COLUMNS);
   localparam int ROW_W          = $clog2(ROWS);
   localparam int LAST_COL       = COLUMNS - 1;
   localparam int LAST_ROW       = ROWS - 1;
   localparam int LAST_ROW_START = CELL_COUNT - COLUMNS;
   localparam int TAB_SPACES     = 4;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_EXEC, S_READ, S_SPACE, S_COPY, S_FILL, S_DONE
   } state_type;

   state_type           state_ff;
   tcw_pkg::opcode_type op_ff;
   logic [7:0]          char_ff;
   logic [7:0]          col_req_ff;
   logic [7:0]          row_req_ff;
   logic [IDX_W-1:0]    cidx_ff;
   logic [COL_W-1:0]    cur_col_ff;
   logic [ROW_W-1:0]    cur_row_ff;
   logic [IDX_W-1:0]    cur_idx_ff;
   logic [IDX_W-1:0]    ptr_ff;
   logic                copy_valid_ff;
   logic [IDX_W-1:0]    copy_dst_ff;
   logic [2:0]          spaces_ff;
   logic                scrolled_ff;
   logic [15:0]         value_ff;
   logic                emit_ff;

   logic [15:0]         mem [CELL_COUNT];
   logic [15:0]         rdata_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [15:0]         mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   logic                at_col_end;
   logic                at_row_end;
   logic [COL_W-1:0]    adv_col;
   logic [ROW_W-1:0]    adv_row;
   logic [IDX_W-1:0]    adv_idx;
   logic                adv_end;
   logic [COL_W-1:0]    set_col;
   logic [ROW_W-1:0]    set_row;
   logic [IDX_W-1:0]    set_idx;
   logic                last_ptr;

   // cursor step by one cell; wrapping past the last cell lands on the last row start
   always_comb begin
      at_col_end = (cur_col_ff == COL_W'(LAST_COL));
      at_row_end = (cur_row_ff == ROW_W'(LAST_ROW));
      adv_col    = '0;
      adv_row    = cur_row_ff;
      adv_idx    = cur_idx_ff + IDX_W'(1);
      adv_end    = 1'b0;
      priority if (!at_col_end) begin
         adv_col = cur_col_ff + COL_W'(1);
      end else if (!at_row_end) begin
         adv_row = cur_row_ff + ROW_W'(1);
      end else begin
         adv_idx = IDX_W'(LAST_ROW_START);
         adv_end = 1'b1;
      end
   end

   always_comb begin
      set_col = ({1'b0, col_req_ff} > 9'(LAST_COL)) ? COL_W'(LAST_COL) : col_req_ff[COL_W-1:0];
      set_row = (row_req_ff > 8'(LAST_ROW)) ? ROW_W'(LAST_ROW) : row_req_ff[ROW_W-1:0];
      set_idx = IDX_W'(32'(set_row) * COLUMNS) + IDX_W'(set_col);
      last_ptr = (ptr_ff == IDX_W'(CELL_COUNT - 1));
   end

   // store port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_idx_ff;
      mem_wdata = tcw_pkg::blank_cell(text_attribute);
      mem_raddr = ptr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = tcw_pkg::blank_cell(tcw_pkg::CLEAR_ATTR);
         end
         S_EXEC: begin
            mem_raddr = cidx_ff;
            if (op_ff == tcw_pkg::OP_PUT) begin
               priority if (char_ff == tcw_pkg::CH_BACKSPACE) begin
                  mem_we    = (cur_idx_ff != '0);
                  mem_waddr = cur_idx_ff - IDX_W'(1);
               end else if (char_ff != tcw_pkg::CH_NEWLINE && char_ff != tcw_pkg::CH_TAB) begin
                  mem_we    = 1'b1;
                  mem_wdata = {text_attribute, char_ff};
               end else begin
                  mem_we    = 1'b0;
               end
            end
         end
         S_SPACE: begin
            mem_we = (spaces_ff != '0);
         end
         S_COPY: begin
            mem_we    = copy_valid_ff;
            mem_waddr = copy_dst_ff;
            mem_wdata = rdata_ff;
         end
         S_FILL: begin
            mem_we = 1'b1;
            if (copy_valid_ff) begin
               mem_waddr = copy_dst_ff;
               mem_wdata = rdata_ff;
            end else begin
               mem_waddr = ptr_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         emit_ff       <= 1'b0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         cur_idx_ff    <= '0;
         copy_valid_ff <= 1'b0;
         spaces_ff     <= '0;
         scrolled_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               ptr_ff <= ptr_ff + IDX_W'(1);
               if (last_ptr) begin
                  state_ff <= emit_ff ? S_DONE : S_IDLE;
               end
            end
            S_IDLE: begin
               if (in_valid) begin
                  op_ff       <= in_opcode;
                  char_ff     <= in_char_code;
                  col_req_ff  <= in_cursor_col;
                  row_req_ff  <= in_cursor_row;
                  cidx_ff     <= in_cell_index;
                  scrolled_ff <= 1'b0;
                  value_ff    <= '0;
                  spaces_ff   <= '0;
                  state_ff    <= S_EXEC;
               end
            end
            S_EXEC: begin
               unique case (op_ff)
                  tcw_pkg::OP_PUT: begin
                     priority if (char_ff == tcw_pkg::CH_NEWLINE) begin
                        cur_col_ff <= '0;
                        if (at_row_end) begin
                           cur_idx_ff  <= IDX_W'(LAST_ROW_START);
                           scrolled_ff <= 1'b1;
                           ptr_ff      <= IDX_W'(COLUMNS);
                           state_ff    <= S_COPY;
                        end else begin
                           cur_row_ff <= cur_row_ff + ROW_W'(1);
                           cur_idx_ff <= cur_idx_ff - IDX_W'(cur_col_ff) + IDX_W'(COLUMNS);
                           state_ff   <= S_DONE;
                        end
                     end else if (char_ff == tcw_pkg::CH_TAB) begin
                        spaces_ff <= 3'(TAB_SPACES);
                        state_ff  <= S_SPACE;
                     end else if (char_ff == tcw_pkg::CH_BACKSPACE) begin
                        if (cur_idx_ff != '0) begin
                           if (cur_col_ff == '0) begin
                              cur_col_ff <= COL_W'(LAST_COL);
                              cur_row_ff <= cur_row_ff - ROW_W'(1);
                           end else begin
                              cur_col_ff <= cur_col_ff - COL_W'(1);
                           end
                           cur_idx_ff <= cur_idx_ff - IDX_W'(1);
                        end
                        state_ff <= S_DONE;
                     end else begin
                        cur_col_ff <= adv_col;
                        cur_row_ff <= adv_row;
                        cur_idx_ff <= adv_idx;
                        if (adv_end) begin
                           scrolled_ff <= 1'b1;
                           ptr_ff      <= IDX_W'(COLUMNS);
                           state_ff    <= S_COPY;
                        end else begin
                           state_ff <= S_DONE;
                        end
                     end
                  end
                  tcw_pkg::OP_SET_CURSOR: begin
                     cur_col_ff <= set_col;
                     cur_row_ff <= set_row;
                     cur_idx_ff <= set_idx;
                     state_ff   <= S_DONE;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     ptr_ff   <= '0;
                     emit_ff  <= 1'b1;
                     state_ff <= S_CLEAR;
                  end
                  tcw_pkg::OP_READ: begin
                     state_ff <= (32'(cidx_ff) < CELL_COUNT) ? S_READ : S_DONE;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_READ: begin
               value_ff <= rdata_ff;
               state_ff <= S_DONE;
            end
            S_SPACE: begin
               if (spaces_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  spaces_ff  <= spaces_ff - 3'd1;
                  cur_col_ff <= adv_col;
                  cur_row_ff <= adv_row;
                  cur_idx_ff <= adv_idx;
                  if (adv_end) begin
                     scrolled_ff <= 1'b1;
                     ptr_ff      <= IDX_W'(COLUMNS);
                     state_ff    <= S_COPY;
                  end
               end
            end
            S_COPY: begin
               copy_valid_ff <= 1'b1;
               copy_dst_ff   <= ptr_ff - IDX_W'(COLUMNS);
               if (last_ptr) begin
                  ptr_ff   <= IDX_W'(LAST_ROW_START);
                  state_ff <= S_FILL;
               end else begin
                  ptr_ff <= ptr_ff + IDX_W'(1);
               end
            end
            S_FILL: begin
               copy_valid_ff <= 1'b0;
               if (!copy_valid_ff) begin
                  if (last_ptr) begin
                     state_ff <= S_SPACE;
                  end else begin
                     ptr_ff <= ptr_ff + IDX_W'(1);
                  end
               end
            end
            S_DONE: begin
               if (out_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign in_ready         = (state_ff == S_IDLE);
   assign out_valid        = (state_ff == S_DONE);
   assign out_cell_value   = value_ff;
   assign out_cursor_index = cur_idx_ff;
   assign out_scrolled     = scrolled_ff;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the text console writer: command stream, result stream, APB.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS     = tcw_pkg::COLUMNS_DEFAULT;
   localparam int ROWS        = tcw_pkg::ROWS_DEFAULT;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int IDX_W       = $clog2(CELL_COUNT);
   localparam int REQ_W       = ((26 + IDX_W + 7) / 8) * 8;
   localparam int RSP_W       = ((17 + IDX_W + 7) / 8) * 8;
   // Slowest correct run: every item scrolls, plus stalls, taken several times over,
   // plus the blanking sweep after reset.
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int LONG_HOLD   = 400;

   typedef struct packed {
      tcw_pkg::opcode_type op;
      logic [7:0]          ch;
      logic [7:0]          col;
      logic [7:0]          row;
      logic [IDX_W-1:0]    idx;
   } console_cmd_type;

   typedef struct packed {
      logic [15:0]      cell_value;
      logic [IDX_W-1:0] cursor;
      logic             scrolled;
   } console_status_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_psel    = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite  = 1'b0;
   logic [1:0]       csr_paddr   = '0;
   logic [31:0]      csr_pwdata  = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   text_console_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // opcode, char_code, cursor_col, cursor_row, cell_index, pad
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // cell_value, cursor_index, scrolled, pad
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Console model: screen contents, cursor and current attribute
   // ---------------------------------------------------------------------
   logic [15:0]        screen_model [CELL_COUNT];
   int unsigned        cursor_model;
   logic [7:0]         attr_model;
   console_cmd_type    command_queue[$];     // items waiting for the sender
   console_status_type console_outcomes[$];  // predicted results, oldest first
   int                 failures;

   // Move every row up by one and blank the bottom row with the current attribute.
   function automatic void scroll_screen();
      for (int k = 0; k < CELL_COUNT - COLUMNS; k++)
         screen_model[k] = screen_model[k + COLUMNS];
      for (int k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++)
         screen_model[k] = {attr_model, tcw_pkg::SPACE_CHAR};
   endfunction

   function automatic void move_cursor(input int unsigned col, input int unsigned row);
      if (col > COLUMNS - 1) col = COLUMNS - 1;
      if (row > ROWS - 1) row = ROWS - 1;
      cursor_model = row * COLUMNS + col;
   endfunction

   // Write one character at the cursor; returns 1 when the screen scrolled.
   function automatic bit write_char(input logic [7:0] code);
      int unsigned pos;
      bit          sc;
      pos = cursor_model;
      sc  = 1'b0;
      if (pos >= CELL_COUNT) begin
         scroll_screen();
         sc = 1'b1;
         move_cursor(0, ROWS - 1);
         pos = cursor_model;
      end
      if (code == tcw_pkg::CH_NEWLINE) begin
         if (pos / COLUMNS >= ROWS - 1) begin
            scroll_screen();
            sc = 1'b1;
            move_cursor(0, ROWS - 1);
         end else begin
            move_cursor(0, pos / COLUMNS + 1);
         end
      end else if (code == tcw_pkg::CH_TAB) begin
         for (int k = 0; k < 4; k++)
            sc |= write_char(tcw_pkg::SPACE_CHAR);
      end else if (code == tcw_pkg::CH_BACKSPACE) begin
         if (pos > 0) begin
            pos--;
            cursor_model = pos;
            screen_model[pos] = {attr_model, tcw_pkg::SPACE_CHAR};
         end
      end else begin
         screen_model[pos] = {attr_model, code};
         pos++;
         move_cursor(pos % COLUMNS, pos / COLUMNS);
         if (pos >= CELL_COUNT) begin
            scroll_screen();
            sc = 1'b1;
         end
      end
      return sc;
   endfunction

   // Run one accepted command through the model and queue the result it should give.
   function automatic void apply_command(input console_cmd_type c);
      console_status_type r;
      r = '0;
      case (c.op)
         tcw_pkg::OP_PUT:        r.scrolled = write_char(c.ch);
         tcw_pkg::OP_SET_CURSOR: move_cursor(c.col, c.row);
         tcw_pkg::OP_CLEAR: begin
            for (int k = 0; k < CELL_COUNT; k++)
               screen_model[k] = {tcw_pkg::CLEAR_ATTR, tcw_pkg::SPACE_CHAR};
         end
         default: begin
            if (c.idx < CELL_COUNT) r.cell_value = screen_model[c.idx];
         end
      endcase
      r.cursor = cursor_model[IDX_W-1:0];
      console_outcomes.push_back(r);
   endfunction

   function automatic console_cmd_type make_command(input tcw_pkg::opcode_type op,
                                                    input logic [7:0] ch,
                                                    input logic [7:0] col,
                                                    input logic [7:0] row,
                                                    input logic [IDX_W-1:0] idx);
      console_cmd_type c;
      c.op  = op;
      c.ch  = ch;
      c.col = col;
      c.row = row;
      c.idx = idx;
      return c;
   endfunction

   // Mostly puts of plain text with the odd control character, some cursor moves and
   // reads, rare clears. Fields that the opcode ignores still carry random bits.
   function automatic console_cmd_type random_command();
      console_cmd_type c;
      int unsigned     pick;
      c.ch  = 8'($urandom_range(0, 255));
      c.col = 8'($urandom_range(0, 255));
      c.row = 8'($urandom_range(0, 255));
      c.idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      pick  = $urandom_range(0, 99);
      if (pick < 62) begin
         c.op = tcw_pkg::OP_PUT;
         pick = $urandom_range(0, 99);
         if (pick < 8)       c.ch = tcw_pkg::CH_NEWLINE;
         else if (pick < 13) c.ch = tcw_pkg::CH_TAB;
         else if (pick < 20) c.ch = tcw_pkg::CH_BACKSPACE;
      end else if (pick < 72) begin
         c.op = tcw_pkg::OP_SET_CURSOR;
         if ($urandom_range(0, 4) != 0) c.col = 8'($urandom_range(0, COLUMNS - 1));
         if ($urandom_range(0, 4) != 0) c.row = 8'($urandom_range(0, ROWS - 1));
      end else if (pick < 74) begin
         c.op = tcw_pkg::OP_CLEAR;
      end else begin
         c.op = tcw_pkg::OP_READ;
         if ($urandom_range(0, 9) != 0) c.idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: bursts of items with random gaps in between
   // ---------------------------------------------------------------------
   console_cmd_type offered_cmd;
   int              burst_left;
   int              gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_command(offered_cmd);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               // A third of the bursts run straight into the next one.
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
         end
         // Hold the offered item until it is taken, then advance.
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (command_queue.size() > 0) begin
               offered_cmd = command_queue.pop_front();
               req_tdata  <= {{(REQ_W - 26 - IDX_W){1'b0}}, offered_cmd.idx, offered_cmd.row,
                              offered_cmd.col, offered_cmd.ch, offered_cmd.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: check every result, stall on a changing duty pattern
   // ---------------------------------------------------------------------
   int hold_requests;
   int holds_served;
   int hold_left;
   int stall_pct;
   int pattern_left;

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      console_status_type want;
      if (reset) begin
         rsp_tready  <= 1'b0;
         holds_served = 0;
         hold_left    = 0;
         stall_pct    = 0;
         pattern_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (console_outcomes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual 0x%0h", $time, rsp_tdata);
               failures++;
            end else begin
               want = console_outcomes.pop_front();
               compare_field("cell_value", want.cell_value, rsp_tdata[15:0]);
               compare_field("cursor_index", want.cursor, rsp_tdata[16 +: IDX_W]);
               compare_field("scrolled", want.scrolled, rsp_tdata[16 + IDX_W]);
            end
         end
         // A requested hold-off blocks the result channel long enough to back up the block.
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (pattern_left <= 0) begin
            pattern_left = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               2:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         pattern_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Register access and phase control
   // ---------------------------------------------------------------------

   // Write the attribute register, then read it back; the block must be idle.
   task automatic write_attribute(input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= tcw_pkg::ADDR_TEXT_ATTRIBUTE;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // The register takes the value at this edge.
      attr_model = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== value) begin
         $display("%0t: text_attribute readback mismatch, expected 0x%0h, actual 0x%0h",
                  $time, value, csr_prdata[7:0]);
         failures++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until every queued item is taken and every predicted result has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (command_queue.size() != 0 || req_tvalid || console_outcomes.size() != 0);
   endtask

   task automatic load_random(input int count);
      repeat (count) command_queue.push_back(random_command());
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL text_console_writer");
      $finish;
   end

   initial begin
      failures      = 0;
      hold_requests = 0;
      cursor_model  = 0;
      attr_model    = tcw_pkg::CLEAR_ATTR;
      for (int k = 0; k < CELL_COUNT; k++)
         screen_model[k] = {tcw_pkg::CLEAR_ATTR, tcw_pkg::SPACE_CHAR};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // Let the blanking sweep after reset finish before touching the register.
      do @(negedge clock);
      while (!req_tready);

      // Directed commands with the brightest attribute.
      write_attribute(8'hFF);
      command_queue.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_READ, 8'hFF, 8'hFF, 8'hFF,
                                           IDX_W'(CELL_COUNT - 1)));
      // out-of-range read gives zero
      command_queue.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 8'h00, 8'h00, '1));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, 8'h41, 8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, 8'hFF, 8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, 8'h00, 8'hFF, 8'hFF, '1));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE,
                                           8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 8'h00, 8'h00,
                                           IDX_W'(1)));
      // backspace at the home position changes nothing
      command_queue.push_back(make_command(tcw_pkg::OP_SET_CURSOR, 8'h00, 8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE,
                                           8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB,
                                           8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE,
                                           8'h00, 8'h00, '0));
      // clamped to the last cell, then a put runs off the end and scrolls
      command_queue.push_back(make_command(tcw_pkg::OP_SET_CURSOR, 8'h00, 8'hFF, 8'hFF, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, 8'h5A, 8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 8'h00, 8'h00,
                                           IDX_W'(CELL_COUNT - COLUMNS - 1)));
      // newline on the bottom row scrolls
      command_queue.push_back(make_command(tcw_pkg::OP_SET_CURSOR, 8'h00, 8'd5,
                                           8'(ROWS - 1), '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE,
                                           8'h00, 8'h00, '0));
      // tab that wraps past the last cell
      command_queue.push_back(make_command(tcw_pkg::OP_SET_CURSOR, 8'h00, 8'(COLUMNS - 2),
                                           8'(ROWS - 1), '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB,
                                           8'h00, 8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 8'h00, 8'h00,
                                           IDX_W'(CELL_COUNT - COLUMNS)));
      command_queue.push_back(make_command(tcw_pkg::OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, '1));
      command_queue.push_back(make_command(tcw_pkg::OP_READ, 8'h00, 8'h00, 8'h00,
                                           IDX_W'(CELL_COUNT - 1)));
      // column clamp alone, then row clamp alone
      command_queue.push_back(make_command(tcw_pkg::OP_SET_CURSOR, 8'h00, 8'(COLUMNS),
                                           8'h00, '0));
      command_queue.push_back(make_command(tcw_pkg::OP_SET_CURSOR, 8'h00, 8'h00,
                                           8'(ROWS), '0));
      command_queue.push_back(make_command(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE,
                                           8'h00, 8'h00, '0));
      wait_drained();

      // Random traffic under the darkest attribute.
      write_attribute(8'h00);
      load_random(150);
      wait_drained();

      // Random traffic with a long result-side hold-off so the input backs up.
      write_attribute(8'($urandom_range(1, 254)));
      load_random(150);
      hold_requests++;
      wait_drained();

      write_attribute(8'($urandom_range(0, 255)));
      load_random(150);
      wait_drained();

      // Drain window: catch any stray result after the last expected one.
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("PASS text_console_writer");
      else
         $display("FAIL text_console_writer");
      $finish;
   end

endmodule
